// File: hw/rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg: shared types and constants for the affine transform accumulator
// Payload structs, operation codes and the CORDIC arctangent table (Q2.30).
// ----------------------------------------------------------------------------
`default_nettype none
package ata_pkg;

  typedef enum logic [1:0] {
    OP_ROTATE    = 2'd0,
    OP_SCALE     = 2'd1,
    OP_TRANSLATE = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]   operation;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
  } out_item_t;

  localparam int ANG_BITS = 30;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;

  // Control handed from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic add_t;
  } mac_ctl_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0:  atan_q30 = 30'd843314857;
      5'd1:  atan_q30 = 30'd497837829;
      5'd2:  atan_q30 = 30'd263043837;
      5'd3:  atan_q30 = 30'd133525159;
      5'd4:  atan_q30 = 30'd67021687;
      5'd5:  atan_q30 = 30'd33543516;
      5'd6:  atan_q30 = 30'd16775851;
      5'd7:  atan_q30 = 30'd8388437;
      5'd8:  atan_q30 = 30'd4194283;
      5'd9:  atan_q30 = 30'd2097149;
      5'd31: atan_q30 = 30'd0;
      default: atan_q30 = 30'd1 << (5'd30 - i);
    endcase
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ata_cordic.sv
// ----------------------------------------------------------------------------
// ata_cordic: rotation-mode CORDIC, one micro-rotation per cycle
// Folds the angle into +-pi/2, runs min(STEPS, 32) micro-rotations, rounds to FRAC_BITS.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_cordic import ata_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int STEPS     = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output logic                    done,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);
  localparam int NSTEP = (STEPS > 32) ? 32 : STEPS;
  localparam int SH    = ANG_BITS - FRAC_BITS;

  logic signed [35:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [5:0]  i_r, i_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic signed [35:0] za, zs, dx, dy, xr, yr, at;

  // angle to Q30, saturate to +-pi (56-bit compare, wide enough for FRAC_BITS >= 6)
  always_comb begin
    za = 36'(angle) <<< SH;
    if ((56'(angle) <<< SH) > 56'(PI_Q30)) za = PI_Q30;
    if ((56'(angle) <<< SH) < -56'(PI_Q30)) za = -PI_Q30;
  end

  assign dx = y_r >>> i_r[4:0];
  assign dy = x_r >>> i_r[4:0];
  assign at = 36'(atan_q30(i_r[4:0]));

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    zs = za;
    if (start) begin
      neg_nxt = 1'b0;
      if (za > HALF_PI_Q30) begin
        zs = za - PI_Q30; neg_nxt = 1'b1;
      end else if (za < -HALF_PI_Q30) begin
        zs = za + PI_Q30; neg_nxt = 1'b1;
      end
      x_nxt = GAIN_Q30; y_nxt = '0; z_nxt = zs; i_nxt = '0;
      busy_nxt = (NSTEP != 0);
      done_nxt = (NSTEP == 0);
    end else if (busy_r) begin
      if (!z_r[35]) begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + at;
      end
      i_nxt = i_r + 6'd1;
      if (i_r == 6'(NSTEP - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; i_r <= i_nxt; neg_r <= neg_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  // round half up to FRAC_BITS, fold sign
  assign xr = (x_r + (36'sd1 <<< (SH - 1))) >>> SH;
  assign yr = (y_r + (36'sd1 <<< (SH - 1))) >>> SH;
  assign cos_o = neg_r ? -34'(xr) : 34'(xr);
  assign sin_o = neg_r ? -34'(yr) : 34'(yr);
  assign done  = done_r;
endmodule
`default_nettype wire

// File: hw/rtl/ata_mac.sv
// ----------------------------------------------------------------------------
// ata_mac: digit-serial multiply-accumulate for one new matrix entry
// Each cycle one 4-bit digit of b is multiplied by a; two products are
// summed, rounded half up at FRAC_BITS, kept term t added if add_t, then saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_mac import ata_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mac_ctl_t           ctl,
  input  wire logic signed [33:0] a1,
  input  wire logic signed [33:0] b1,
  input  wire logic signed [33:0] a2,
  input  wire logic signed [33:0] b2,
  input  wire logic signed [31:0] t,
  output logic                    done,
  output logic signed [31:0]      result
);
  // 34-bit b operand -> 9 digits of 4 bits (36 bits, sign-extended)
  localparam int NDIG = 9;

  logic signed [35:0] bs_r, bs_nxt;
  logic signed [33:0] a_r, a_nxt, a2_r;
  logic signed [35:0] b2_r;
  logic signed [79:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        sec_r, sec_nxt, busy_r, busy_nxt, done_r, done_nxt, addt_r;
  logic signed [31:0] t_r, res_r, res_nxt;
  logic signed [38:0] pp;
  logic [3:0]  dig;
  logic signed [79:0] rnd, tot;

  assign dig = bs_r[3:0];
  // top digit carries the sign
  assign pp = (cnt_r == 5'(NDIG - 1)) ? 39'(a_r) * 39'($signed(dig))
                                      : 39'(a_r) * $signed({35'd0, dig});

  always_comb begin
    bs_nxt = bs_r; a_nxt = a_r; acc_nxt = acc_r; cnt_nxt = cnt_r;
    sec_nxt = sec_r; busy_nxt = busy_r; done_nxt = 1'b0; res_nxt = res_r;
    rnd = '0; tot = '0;
    if (ctl.start) begin
      bs_nxt = 36'(b1); a_nxt = a1; acc_nxt = '0; cnt_nxt = '0;
      sec_nxt = 1'b0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + (80'(pp) <<< (cnt_r * 4));
      bs_nxt = bs_r >>> 4;
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(NDIG - 1)) begin
        cnt_nxt = '0;
        if (!sec_r) begin
          sec_nxt = 1'b1; a_nxt = a2_r; bs_nxt = b2_r;
        end else begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
          rnd = (acc_nxt + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
          tot = rnd + (addt_r ? 80'(t_r) : 80'sd0);
          if (tot > 80'sd2147483647) res_nxt = 32'sh7fffffff;
          else if (tot < -80'sd2147483648) res_nxt = 32'sh80000000;
          else res_nxt = tot[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    bs_r <= bs_nxt; a_r <= a_nxt; acc_r <= acc_nxt; cnt_r <= cnt_nxt;
    sec_r <= sec_nxt; res_r <= res_nxt;
    if (ctl.start) begin
      a2_r <= a2; b2_r <= 36'(b2); t_r <= t; addt_r <= ctl.add_t;
    end
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign result = res_r;
endmodule
`default_nettype wire

// File: hw/rtl/affine_transform_accumulator.sv
// ----------------------------------------------------------------------------
// affine_transform_accumulator: 2D homogeneous transform composition
// Post-multiplies a stored 2x3 Q16.16 matrix by rotate/scale/translate.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// in      | input     | in_valid/in_stall | in_item_t (operation, value_x/y)
// out     | output    | out_valid/out_stall | out_item_t (m00..m12)
//
// One transaction at a time. Each new entry is built from a start, the
// digit-serial MAC steps (two products of 9 four-bit digits) and a hand-off.
// Rotate/scale update four entries, translate two; a rotate runs the CORDIC
// first and OP_NONE goes straight to the output. out_valid rises in the same
// cycle that the block returns to idle, so the next input can be taken then.
// Reset loads the identity. A held result blocks only when the next one is due.
// ----------------------------------------------------------------------------
`default_nettype none
module affine_transform_accumulator import ata_pkg::*; #(
  parameter int FRAC_BITS      = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_COR  = 5'b00010,
    S_MAC  = 5'b00100,
    S_WAIT = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [31:0] m_r [6];
  logic signed [31:0] newv_r [4];
  in_item_t  it_r;
  logic [1:0] k_r, k_nxt;
  logic signed [33:0] c_r, s_r;
  logic       ov_r, ov_nxt;
  logic       out_load;
  out_item_t  od_r;
  logic       cor_start, cor_done, mac_done;
  logic signed [33:0] cos_w, sin_w, a1, b1, a2, b2;
  logic signed [31:0] tt, mac_res;
  mac_ctl_t   mctl;
  logic [1:0] nk;
  logic [2:0] r0;

  ata_cordic #(.FRAC_BITS(FRAC_BITS), .STEPS(ROTATION_STEPS)) u_cordic (
    .clk, .rst_n, .start(cor_start), .angle(it_r.value_x),
    .done(cor_done), .cos_o(cos_w), .sin_o(sin_w)
  );

  ata_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk, .rst_n, .ctl(mctl), .a1, .b1, .a2, .b2, .t(tt),
    .done(mac_done), .result(mac_res)
  );

  // entries per operation: rotate/scale 4 (k: r0c0,r0c1,r1c0,r1c1), translate 2
  assign nk = (op_t'(it_r.operation) == OP_TRANSLATE) ? 2'd1 : 2'd3;
  assign r0 = k_r[1] ? 3'd3 : 3'd0;

  // operand selection for the current entry
  always_comb begin
    a1 = '0; b1 = '0; a2 = '0; b2 = '0; tt = '0;
    unique case (op_t'(it_r.operation))
      OP_ROTATE: begin
        if (!k_r[0]) begin
          // a*c + b*s
          a1 = 34'(m_r[r0]); b1 = c_r; a2 = 34'(m_r[r0 + 3'd1]); b2 = s_r;
        end else begin
          // b*c - a*s
          a1 = 34'(m_r[r0 + 3'd1]); b1 = c_r; a2 = 34'(m_r[r0]); b2 = -s_r;
        end
      end
      OP_SCALE: begin
        a1 = 34'(m_r[r0 + 3'(k_r[0])]);
        b1 = k_r[0] ? 34'(it_r.value_y) : 34'(it_r.value_x);
      end
      OP_TRANSLATE: begin
        a1 = 34'(m_r[k_r[0] ? 3'd3 : 3'd0]); b1 = 34'(it_r.value_x);
        a2 = 34'(m_r[k_r[0] ? 3'd4 : 3'd1]); b2 = 34'(it_r.value_y);
        tt = m_r[k_r[0] ? 3'd5 : 3'd2];
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r; k_nxt = k_r; ov_nxt = ov_r;
    out_load = 1'b0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        k_nxt = '0;
        unique case (op_t'(in_data.operation))
          OP_ROTATE: state_nxt = S_COR;
          OP_NONE:   state_nxt = S_OUT;
          default:   state_nxt = S_MAC;
        endcase
      end
      S_COR: state_nxt = S_WAIT;
      S_WAIT: if (cor_done || op_t'(it_r.operation) != OP_ROTATE) begin
        state_nxt = S_MAC;
      end
      // left through the commit path once the last entry is done
      S_MAC: state_nxt = S_MAC;
      S_OUT: if (!ov_nxt) begin
        ov_nxt = 1'b1; out_load = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cor_start = (state_r == S_COR);
  end

  // MAC issue tracking
  logic busy_r, busy_nxt;
  always_comb begin
    busy_nxt = busy_r;
    mctl = '0;
    if (state_r == S_MAC && !busy_r) begin
      mctl.start = 1'b1;
      mctl.add_t = (op_t'(it_r.operation) == OP_TRANSLATE);
      busy_nxt = 1'b1;
    end else if (busy_r && mac_done) begin
      busy_nxt = 1'b0;
    end
  end

  logic to_out;
  assign to_out = busy_r && mac_done && (k_r == nk);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) it_r <= in_data;
    if (cor_done) begin
      c_r <= cos_w; s_r <= sin_w;
    end
    if (busy_r && mac_done) newv_r[k_r] <= mac_res;
    // commit all new entries together
    if (to_out) begin
      unique case (op_t'(it_r.operation))
        OP_ROTATE, OP_SCALE: begin
          m_r[0] <= newv_r[0]; m_r[1] <= newv_r[1];
          m_r[3] <= newv_r[2]; m_r[4] <= mac_res;
        end
        OP_TRANSLATE: begin
          m_r[2] <= newv_r[0]; m_r[5] <= mac_res;
        end
        default: ;
      endcase
    end
    if (out_load) od_r <= '{m_r[0], m_r[1], m_r[2], m_r[3], m_r[4], m_r[5]};
    if (!rst_n) begin
      state_r <= S_IDLE; k_r <= '0; ov_r <= 1'b0; busy_r <= 1'b0;
      m_r[0] <= 32'sd1 <<< FRAC_BITS; m_r[1] <= '0; m_r[2] <= '0;
      m_r[3] <= '0; m_r[4] <= 32'sd1 <<< FRAC_BITS; m_r[5] <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r <= ov_nxt;
      if (to_out) begin
        state_r <= S_OUT; k_r <= '0;
      end else begin
        state_r <= state_nxt;
        if (busy_r && mac_done) k_r <= k_r + 2'd1;
        else if (state_r == S_IDLE) k_r <= k_nxt;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
`default_nettype wire

// File: hw/rtl/ata_checker.sv
// ----------------------------------------------------------------------------
// ata_checker: port-level checks for the affine transform accumulator
// Watches handshakes, one-at-a-time acceptance and that no result rises at once.
// ----------------------------------------------------------------------------
`default_nettype none
module ata_checker import ata_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);
  // a stalled input holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // an accepted input stalls the channel in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input taken while busy");

  // no result right after an acceptance
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");
endmodule

bind affine_transform_accumulator ata_checker u_ata_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);
`default_nettype wire

// File: verif/affine_transform_accumulator_tb.sv
// ----------------------------------------------------------------------------
// affine_transform_accumulator_tb: self-checking bench for the transform block
// Drives rotate/scale/translate/no-op transactions with random gaps, predicts the
// stored 2x3 Q16.16 matrix after each one and compares every returned matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module affine_transform_accumulator_tb;
  import ata_pkg::*;

  localparam int FRAC = 16;
  localparam int STEPS = 16;
  localparam int LONGEST_QUIET = 20000;
  localparam longint Q_ONE = 64'sd1 << FRAC;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  affine_transform_accumulator #(.FRAC_BITS(FRAC), .ROTATION_STEPS(STEPS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  in_item_t  pending_items[$];
  out_item_t expected_matrices[$];
  logic signed [31:0] mat[6];
  int  mismatch_count;
  int  quiet_cycles;
  bit  stimulus_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Arithmetic right shift with floor
  function automatic longint floor_shift(longint v, int s);
    floor_shift = v >>> s;
  endfunction

  function automatic logic signed [31:0] saturate(longint v);
    if (v > 64'sd2147483647) saturate = 32'sh7fffffff;
    else if (v < -64'sd2147483648) saturate = 32'sh80000000;
    else saturate = v[31:0];
  endfunction

  // a1*b1 + a2*b2 rounded half up at FRAC fraction bits (exact via 128 bits)
  function automatic longint round_products(longint a1, longint b1,
                                            longint a2, longint b2);
    logic signed [127:0] acc;
    acc = 128'(a1) * 128'(b1) + 128'(a2) * 128'(b2) + (128'sd1 <<< (FRAC - 1));
    round_products = longint'(acc >>> FRAC);
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                        524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                        2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    atan_entry = tbl[i];
  endfunction

  // Sine and cosine of a Q16.16 angle, CORDIC in Q2.30
  task automatic sin_cos(input longint angle, output longint c, output longint s);
    longint z, x, y, dx, dy, half;
    bit flip;
    z = angle * (64'sd1 << (30 - FRAC));
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd3373259426) z = 64'sd3373259426;
    if (z < -64'sd3373259426) z = -64'sd3373259426;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 32; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    half = 64'sd1 << (30 - FRAC - 1);
    x = floor_shift(x + half, 30 - FRAC);
    y = floor_shift(y + half, 30 - FRAC);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Post-multiply the predicted matrix and queue the expected result
  task automatic apply_transform(input in_item_t it);
    longint a, b, t, c, s, vx, vy;
    out_item_t m;
    vx = longint'(it.value_x);
    vy = longint'(it.value_y);
    if (op_t'(it.operation) == OP_ROTATE) sin_cos(vx, c, s);
    for (int r = 0; r < 2; r++) begin
      a = mat[r*3]; b = mat[r*3+1]; t = mat[r*3+2];
      case (op_t'(it.operation))
        OP_ROTATE: begin
          mat[r*3]   = saturate(round_products(a, c, b, s));
          mat[r*3+1] = saturate(round_products(a, -s, b, c));
        end
        OP_SCALE: begin
          mat[r*3]   = saturate(round_products(a, vx, 0, 0));
          mat[r*3+1] = saturate(round_products(b, vy, 0, 0));
        end
        OP_TRANSLATE: mat[r*3+2] = saturate(t + round_products(a, vx, b, vy));
        default: ;
      endcase
    end
    m = '{mat[0], mat[1], mat[2], mat[3], mat[4], mat[5]};
    expected_matrices.push_back(m);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) gap_length = 0;
    else if (r < 90) gap_length = $urandom_range(1, 3);
    else gap_length = $urandom_range(10, 60);
  endfunction

  function automatic in_item_t make_item(op_t op, logic [31:0] x, logic [31:0] y);
    make_item.operation = op;
    make_item.value_x = x;
    make_item.value_y = y;
  endfunction

  // Random angle, mostly within +-pi, sometimes anything
  function automatic logic [31:0] rand_angle();
    if ($urandom_range(0, 9) == 0) rand_angle = $urandom();
    else rand_angle = 32'($signed($urandom_range(0, 411774)) - 205887);
  endfunction

  // Random scale near one so the matrix stays in range, sometimes wild
  function automatic logic [31:0] rand_scale();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) rand_scale = $urandom();
    else if (r < 3) rand_scale = 32'($signed($urandom_range(0, 65536)) - 32768);
    else rand_scale = 32'($signed($urandom_range(45000, 90000))
                          * ($urandom_range(0, 3) == 0 ? -1 : 1));
  endfunction

  // Stimulus
  initial begin
    in_item_t it;
    int r;
    logic [31:0] corner[6];
    mismatch_count = 0;
    stimulus_done = 0;
    // nonzero corners only: a zero 2x2 part can never be rebuilt
    corner = '{32'h1, 32'hffff0000, 32'hffffffff, 32'h7fffffff,
               32'h80000000, 32'h00010000};
    pending_items.push_back(make_item(OP_NONE, 32'h12345678, 32'h9abcdef0));
    pending_items.push_back(make_item(OP_ROTATE, 32'd0, 32'hffffffff));
    pending_items.push_back(make_item(OP_ROTATE, 32'sd205887, 32'd0));
    pending_items.push_back(make_item(OP_ROTATE, -32'sd205887, 32'd0));
    pending_items.push_back(make_item(OP_ROTATE, 32'sd102944, 32'd0));
    pending_items.push_back(make_item(OP_ROTATE, 32'h7fffffff, 32'd0));
    pending_items.push_back(make_item(OP_ROTATE, 32'h80000000, 32'd0));
    pending_items.push_back(make_item(OP_ROTATE, 32'sd150000, 32'd0));
    pending_items.push_back(make_item(OP_TRANSLATE, 32'h7fffffff, 32'h7fffffff));
    pending_items.push_back(make_item(OP_TRANSLATE, 32'h80000000, 32'h80000000));
    pending_items.push_back(make_item(OP_TRANSLATE, 32'h00018000, 32'hfffe8000));
    pending_items.push_back(make_item(OP_SCALE, 32'h7fffffff, 32'h80000000));
    pending_items.push_back(make_item(OP_SCALE, 32'h80000000, 32'h7fffffff));
    pending_items.push_back(make_item(OP_SCALE, 32'h00000001, 32'hffffffff));
    // Rebuild a nonzero matrix, then random traffic
    for (int n = 0; n < 1400; n++) begin
      r = $urandom_range(0, 99);
      if (n % 200 == 0 || r < 3) begin
        it = make_item(OP_SCALE, 32'h00010000, 32'h00010000);
        pending_items.push_back(make_item(OP_SCALE, corner[$urandom_range(0, 5)],
                                          corner[$urandom_range(0, 5)]));
        it.value_x = $urandom_range(1, 3) << 16;
        it.value_y = $urandom_range(1, 3) << 16;
      end else if (r < 40) it = make_item(OP_ROTATE, rand_angle(), $urandom());
      else if (r < 65) it = make_item(OP_SCALE, rand_scale(), rand_scale());
      else if (r < 95) it = make_item(OP_TRANSLATE, $urandom(), $urandom());
      else it = make_item(OP_NONE, $urandom(), $urandom());
      pending_items.push_back(it);
    end
    // Zero scale last, since it clears the matrix for good
    pending_items.push_back(make_item(OP_SCALE, 32'd0, 32'd0));
    pending_items.push_back(make_item(OP_TRANSLATE, 32'h00010000, 32'h00010000));
    pending_items.push_back(make_item(OP_NONE, 32'd0, 32'd0));
    stimulus_done = 1;
  end

  // Reset, then wait for drain
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && pending_items.size() == 0 && !in_valid
          && expected_matrices.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_matrices.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Driver: present pending transactions with random gaps
  int drive_gap;
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      drive_gap <= 0;
      for (int k = 0; k < 6; k++) mat[k] = '0;
      mat[0] = 32'(Q_ONE);
      mat[4] = 32'(Q_ONE);
    end else if (in_valid && !in_stall) begin
      apply_transform(in_data);
      void'(pending_items.pop_front());
      gap = gap_length();
      drive_gap <= gap;
      if (gap == 0 && pending_items.size() > 0) begin
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (drive_gap > 0) drive_gap <= drive_gap - 1;
      else if (pending_items.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0];
      end
    end
  end

  // Monitor: random stall and result check
  int stall_left;
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_matrices.size() == 0) begin
          report_mismatch("unexpected result", out_data.m00, 32'h0);
        end else begin
          want = expected_matrices.pop_front();
          if (out_data.m00 !== want.m00) report_mismatch("m00", out_data.m00, want.m00);
          if (out_data.m01 !== want.m01) report_mismatch("m01", out_data.m01, want.m01);
          if (out_data.m02 !== want.m02) report_mismatch("m02", out_data.m02, want.m02);
          if (out_data.m10 !== want.m10) report_mismatch("m10", out_data.m10, want.m10);
          if (out_data.m11 !== want.m11) report_mismatch("m11", out_data.m11, want.m11);
          if (out_data.m12 !== want.m12) report_mismatch("m12", out_data.m12, want.m12);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        stall_left <= gap_length();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else if (quiet_cycles >= LONGEST_QUIET) begin
      $display("end of test: mismatches");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

endmodule
